// ===== sv/q2e_pkg.sv =====
// ============================================================================
// q2e_pkg
// Shared constants and helpers for the quaternion to Euler angle converter.
// ============================================================================
package q2e_pkg;

    localparam int TAB_LEN = 24;
    localparam int ACC_W   = 26;
    localparam int SQW     = 62;
    localparam int SQ_STEPS = 31;

    localparam logic signed [ACC_W-1:0] DEG90 = ACC_W'(90 * 65536);

    localparam logic signed [17:0] ROLL_LIM  = 18'sd23040;
    localparam logic signed [17:0] PITCH_LIM = 18'sd11520;

    // atan(2^-i) in degrees, scaled by 65536
    localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    function automatic logic signed [17:0] acc_round(
        input logic signed [ACC_W-1:0] acc,
        input logic                    zero,
        input logic signed [17:0]      lim
    );
        logic signed [ACC_W:0] t;
        logic signed [17:0]    r;
        t = {acc[ACC_W-1], acc} + (ACC_W+1)'(256);
        r = t[ACC_W:9];
        if (zero)
            r = '0;
        else if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r;
    endfunction

endpackage

// ===== sv/q2e_sqrt_cell.sv =====
// ============================================================================
// q2e_sqrt_cell
// One restoring step of the integer square root, registered.
// ============================================================================
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [q2e_pkg::SQW-1:0] v_in,
    input  logic [q2e_pkg::SQW-1:0] r_in,
    output logic [q2e_pkg::SQW-1:0] v_out,
    output logic [q2e_pkg::SQW-1:0] r_out
);
    import q2e_pkg::*;

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    logic [SQW-1:0] trial;
    logic [SQW-1:0] v_next;
    logic [SQW-1:0] r_next;

    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out <= v_next;
            r_out <= r_next;
        end
    end

endmodule

// ===== sv/q2e_cordic_pre.sv =====
// ============================================================================
// q2e_cordic_pre
// Quadrant fold ahead of the CORDIC chain, with zero-vector flag.
// ============================================================================
module q2e_cordic_pre #(
    parameter int CW = 37
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [q2e_pkg::ACC_W-1:0] acc_out,
    output logic                 zero_out
);
    import q2e_pkg::*;

    logic signed [CW-1:0]    x_next;
    logic signed [CW-1:0]    y_next;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        x_next   = x_in;
        y_next   = y_in;
        acc_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next   = y_in;
                y_next   = -x_in;
                acc_next = DEG90;
            end
            else
            begin
                x_next   = -y_in;
                y_next   = x_in;
                acc_next = -DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out    <= x_next;
            y_out    <= y_next;
            acc_out  <= acc_next;
            zero_out <= (x_in == 0) && (y_in == 0);
        end
    end

endmodule

// ===== sv/q2e_cordic_cell.sv =====
// ============================================================================
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ============================================================================
module q2e_cordic_cell #(
    parameter int CW    = 37,
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [q2e_pkg::ACC_W-1:0] acc_in,
    input  logic                 zero_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [q2e_pkg::ACC_W-1:0] acc_out,
    output logic                 zero_out
);
    import q2e_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = x_in >>> STAGE;
    assign dy = y_in >>> STAGE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in >= 0)
            begin
                x_out   <= x_in + dy;
                y_out   <= y_in - dx;
                acc_out <= acc_in + ATAN_TAB[STAGE];
            end
            else
            begin
                x_out   <= x_in - dy;
                y_out   <= y_in + dx;
                acc_out <= acc_in - ATAN_TAB[STAGE];
            end
            zero_out <= zero_in;
        end
    end

endmodule

// ===== sv/quaternion_to_euler_angles_top.sv =====
// ============================================================================
// quaternion_to_euler_angles_top
// Unit quaternion to ZYX Euler angles (roll, pitch, yaw) in 1/128 degree.
// ============================================================================
// Fully pipelined: one quaternion per cycle unless stalled by the output
// buffer. Stages: three product/sum stages, a 31-cell square-root chain for
// the pitch cosine, a quadrant fold, one CORDIC cell per stage, then the
// output register. A two-entry output buffer keeps s_axis_tready registered;
// the pipe stalls as a whole only when both entries are held.
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES  = 16,
    parameter int QUAT_FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll_deg, pitch_deg, yaw_deg, pad
);
    import q2e_pkg::*;

    localparam int F2  = 2 * QUAT_FRAC_BITS;
    localparam int CW  = ((F2 > 33) ? F2 : 33) + 4;
    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 35 + N;
    localparam logic signed [CW-1:0] ONE = CW'(1) << F2;

    logic en;
    logic [LAT-1:0] vld_reg;

    // stage 1: products
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wz_reg, xy_reg, wy_reg, zx_reg;

    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    // stage 2: atan2 operands and pitch sine
    logic signed [CW-1:0] rn_next, rd_next, yn_next, yd_next, s_raw, s_cl, s_sc;
    logic signed [CW-1:0] rn_reg, rd_reg, yn_reg, yd_reg;
    logic signed [31:0]   s30_reg;

    always_comb
    begin
        rn_next = (CW'(wx_reg) + CW'(yz_reg)) <<< 1;
        rd_next = ONE - ((CW'(xx_reg) + CW'(yy_reg)) <<< 1);
        yn_next = (CW'(wz_reg) + CW'(xy_reg)) <<< 1;
        yd_next = ONE - ((CW'(yy_reg) + CW'(zz_reg)) <<< 1);
        s_raw   = (CW'(wy_reg) - CW'(zx_reg)) <<< 1;
        if (s_raw > ONE)
            s_cl = ONE;
        else if (s_raw < -ONE)
            s_cl = -ONE;
        else
            s_cl = s_raw;
    end

    generate
        if (F2 >= 30)
        begin : g_s_down
            assign s_sc = s_cl >>> (F2 - 30);
        end
        else
        begin : g_s_up
            assign s_sc = s_cl <<< (30 - F2);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn_reg  <= rn_next;
            rd_reg  <= rd_next;
            yn_reg  <= yn_next;
            yd_reg  <= yd_next;
            s30_reg <= s_sc[31:0];
        end
    end

    // stage 3: 1 - s^2 and delay line alongside the root chain
    logic signed [63:0]   sq;
    logic [SQW-1:0]       v_w [SQ_STEPS+1];
    logic [SQW-1:0]       r_w [SQ_STEPS+1];
    logic signed [CW-1:0] rn_dl_reg [SQ_STEPS+1];
    logic signed [CW-1:0] rd_dl_reg [SQ_STEPS+1];
    logic signed [CW-1:0] yn_dl_reg [SQ_STEPS+1];
    logic signed [CW-1:0] yd_dl_reg [SQ_STEPS+1];
    logic signed [31:0]   s_dl_reg  [SQ_STEPS+1];

    assign sq     = s30_reg * s30_reg;
    assign r_w[0] = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_w[0]       <= (SQW'(1) << 60) - SQW'(sq[60:0]);
            rn_dl_reg[0] <= rn_reg;
            rd_dl_reg[0] <= rd_reg;
            yn_dl_reg[0] <= yn_reg;
            yd_dl_reg[0] <= yd_reg;
            s_dl_reg[0]  <= s30_reg;
            for (int i = 1; i <= SQ_STEPS; i++)
            begin
                rn_dl_reg[i] <= rn_dl_reg[i-1];
                rd_dl_reg[i] <= rd_dl_reg[i-1];
                yn_dl_reg[i] <= yn_dl_reg[i-1];
                yd_dl_reg[i] <= yd_dl_reg[i-1];
                s_dl_reg[i]  <= s_dl_reg[i-1];
            end
        end
    end

    genvar gi, gc;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sqrt
            q2e_sqrt_cell #(.K(SQ_STEPS - 1 - gi)) u_cell (
                .clk   (clk),
                .en    (en),
                .v_in  (v_w[gi]),
                .r_in  (r_w[gi]),
                .v_out (v_w[gi+1]),
                .r_out (r_w[gi+1])
            );
        end
    endgenerate

    // CORDIC chains: 0 roll, 1 pitch, 2 yaw
    logic signed [CW-1:0]    cx [3];
    logic signed [CW-1:0]    cy [3];
    logic signed [CW-1:0]    x_w   [3][N+1];
    logic signed [CW-1:0]    y_w   [3][N+1];
    logic signed [ACC_W-1:0] acc_w [3][N+1];
    logic                    z_w   [3][N+1];

    assign cx[0] = rd_dl_reg[SQ_STEPS];
    assign cy[0] = rn_dl_reg[SQ_STEPS];
    assign cx[1] = CW'(r_w[SQ_STEPS][30:0]);
    assign cy[1] = CW'(s_dl_reg[SQ_STEPS]);
    assign cx[2] = yd_dl_reg[SQ_STEPS];
    assign cy[2] = yn_dl_reg[SQ_STEPS];

    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_ch
            q2e_cordic_pre #(.CW(CW)) u_pre (
                .clk      (clk),
                .en       (en),
                .x_in     (cx[gc]),
                .y_in     (cy[gc]),
                .x_out    (x_w[gc][0]),
                .y_out    (y_w[gc][0]),
                .acc_out  (acc_w[gc][0]),
                .zero_out (z_w[gc][0])
            );
            for (gi = 0; gi < N; gi++)
            begin : g_cell
                q2e_cordic_cell #(.CW(CW), .STAGE(gi)) u_cell (
                    .clk      (clk),
                    .en       (en),
                    .x_in     (x_w[gc][gi]),
                    .y_in     (y_w[gc][gi]),
                    .acc_in   (acc_w[gc][gi]),
                    .zero_in  (z_w[gc][gi]),
                    .x_out    (x_w[gc][gi+1]),
                    .y_out    (y_w[gc][gi+1]),
                    .acc_out  (acc_w[gc][gi+1]),
                    .zero_out (z_w[gc][gi+1])
                );
            end
        end
    endgenerate

    // rounding, saturation, output buffer
    logic signed [17:0] roll_r, pitch_r, yaw_r;
    logic [47:0] res;
    logic [47:0] out_data_reg, skid_data_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        tail_valid;

    assign roll_r  = acc_round(acc_w[0][N], z_w[0][N], ROLL_LIM);
    assign pitch_r = acc_round(acc_w[1][N], z_w[1][N], PITCH_LIM);
    assign yaw_r   = acc_round(acc_w[2][N], z_w[2][N], ROLL_LIM);
    assign res     = {1'b0, yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign tail_valid    = vld_reg[LAT-1];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            if (skid_valid_reg)
            begin
                if (m_axis_tready)
                    skid_valid_reg <= 1'b0;
            end
            else if (tail_valid)
            begin
                if (!out_valid_reg || m_axis_tready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (tail_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
                out_data_reg <= res;
            else
                skid_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_data_reg[30:16]) <= 15'sd11520 &&
                           $signed(out_data_reg[30:16]) >= -15'sd11520))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_data_reg[15:0]) <= 16'sd23040 &&
                           $signed(out_data_reg[15:0]) >= -16'sd23040))
        else $error("roll out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("buffered result lost");
`endif

endmodule
